// ===== src/rba_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the beam altitude unit.
// No dependencies; every other file of the unit but rba_sqrt refers to it by scoped names.
`timescale 1ns / 1ps

package rba_pkg;

    // configuration register indexes
    typedef enum logic [0:0]
    {
        CFG_SITE_ALT   = 1'b0,
        CFG_EFF_RADIUS = 1'b1
    } cfg_index_t;

    localparam logic [23:0] EFF_RADIUS_RESET = 24'd8494667;

    // angle scaling: pi/180 * 2^36, applied to 1/1024 degree units
    localparam logic [30:0] DEG_TO_RAD_Q46 = 31'd1199381129;
    localparam logic signed [18:0] QUARTER_TURN = 19'sd92160;
    localparam logic signed [18:0] HALF_TURN    = 19'sd184320;

    // CORDIC start vector and sine clamp, Q30
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30         = 34'sd1073741824;

    // output limits
    localparam logic signed [24:0] OUT_MAX = 25'sd16777215;
    localparam logic signed [24:0] OUT_MIN = -25'sd16777216;

    // arctangent of 2^-i in Q30 radians
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0:       v = 32'd843314857;
                1:       v = 32'd497837829;
                2:       v = 32'd263043837;
                3:       v = 32'd133525159;
                4:       v = 32'd67021687;
                5:       v = 32'd33543516;
                6:       v = 32'd16775851;
                7:       v = 32'd8388437;
                8:       v = 32'd4194283;
                9:       v = 32'd2097149;
                10:      v = 32'd1048576;
                11:      v = 32'd524288;
                12:      v = 32'd262144;
                13:      v = 32'd131072;
                14:      v = 32'd65536;
                15:      v = 32'd32768;
                16:      v = 32'd16384;
                17:      v = 32'd8192;
                18:      v = 32'd4096;
                19:      v = 32'd2048;
                20:      v = 32'd1024;
                21:      v = 32'd512;
                22:      v = 32'd256;
                23:      v = 32'd128;
                24:      v = 32'd64;
                25:      v = 32'd32;
                26:      v = 32'd16;
                27:      v = 32'd8;
                28:      v = 32'd4;
                29:      v = 32'd2;
                default: v = 32'd1;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== src/rba_angle.sv =====
// Elevation fold and conversion to a Q30 radian angle, one register stage.
// Depends on rba_pkg for the turn limits and the scale constant.
`timescale 1ns / 1ps

module rba_angle
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [19:0]        in_range,
    input  logic signed [17:0] in_elev,
    output logic               out_vld,
    output logic [19:0]        out_range,
    output logic signed [32:0] out_z
);

    logic signed [18:0] e_ext;
    logic signed [18:0] fold;
    logic [16:0]        mag;
    logic [47:0]        prod;
    logic [31:0]        theta;
    logic signed [32:0] z_next;

    logic               vld_reg;
    logic [19:0]        range_reg;
    logic signed [32:0] z_reg;

    // fold beyond +-90 degrees, scale magnitude, round half up, restore sign
    always_comb
    begin
        e_ext = {in_elev[17], in_elev};
        if (e_ext > rba_pkg::QUARTER_TURN)
            fold = rba_pkg::HALF_TURN - e_ext;
        else if (e_ext < -rba_pkg::QUARTER_TURN)
            fold = -rba_pkg::HALF_TURN - e_ext;
        else
            fold = e_ext;
        mag    = fold[18] ? 17'(-fold) : 17'(fold);
        prod   = 48'(mag) * 48'(rba_pkg::DEG_TO_RAD_Q46);
        theta  = 32'((prod + 48'd32768) >> 16);
        z_next = fold[18] ? -$signed({1'b0, theta}) : $signed({1'b0, theta});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            range_reg <= in_range;
            z_reg     <= z_next;
        end
    end

    assign out_vld   = vld_reg;
    assign out_range = range_reg;
    assign out_z     = z_reg;

endmodule

// ===== src/rba_cordic.sv =====
// Rotation-mode CORDIC sine, one iteration per register stage.
// Depends on rba_pkg for the arctangent table and the start gain.
`timescale 1ns / 1ps

module rba_cordic
#(
    parameter int STEPS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [19:0]        in_range,
    input  logic signed [32:0] in_z,
    output logic               out_vld,
    output logic [19:0]        out_range,
    output logic signed [33:0] out_y
);

    logic               vld_reg   [1:STEPS];
    logic [19:0]        range_reg [1:STEPS];
    logic signed [33:0] x_reg     [1:STEPS];
    logic signed [33:0] y_reg     [1:STEPS];
    logic signed [32:0] z_reg     [1:STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_step
            logic               v_cur;
            logic [19:0]        r_cur;
            logic signed [33:0] x_cur;
            logic signed [33:0] y_cur;
            logic signed [32:0] z_cur;
            logic signed [32:0] ang;
            logic signed [33:0] x_next;
            logic signed [33:0] y_next;
            logic signed [32:0] z_next;

            // stage input: the port for the first step, the previous register after
            if (i == 0)
            begin : g_src_in
                assign v_cur = in_vld;
                assign r_cur = in_range;
                assign x_cur = rba_pkg::CORDIC_GAIN_Q30;
                assign y_cur = '0;
                assign z_cur = in_z;
            end
            else
            begin : g_src_reg
                assign v_cur = vld_reg[i];
                assign r_cur = range_reg[i];
                assign x_cur = x_reg[i];
                assign y_cur = y_reg[i];
                assign z_cur = z_reg[i];
            end

            assign ang = $signed({1'b0, rba_pkg::atan_q30(i)});

            // rotate toward zero residual angle
            always_comb
            begin
                if (!z_cur[32])
                begin
                    x_next = x_cur - (y_cur >>> i);
                    y_next = y_cur + (x_cur >>> i);
                    z_next = z_cur - ang;
                end
                else
                begin
                    x_next = x_cur + (y_cur >>> i);
                    y_next = y_cur - (x_cur >>> i);
                    z_next = z_cur + ang;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i+1] <= 1'b0;
                else if (en)
                    vld_reg[i+1] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    range_reg[i+1] <= r_cur;
                    x_reg[i+1]     <= x_next;
                    y_reg[i+1]     <= y_next;
                    z_reg[i+1]     <= z_next;
                end
            end
        end
    endgenerate

    assign out_vld   = vld_reg[STEPS];
    assign out_range = range_reg[STEPS];
    assign out_y     = y_reg[STEPS];

endmodule

// ===== src/rba_sqrt.sv =====
// Pipelined restoring floor square root, one result bit per register stage.
// Extra fraction pairs or a pre-shift follow from FRAC_BITS; uses no package items.
`timescale 1ns / 1ps

module rba_sqrt
#(
    parameter int FRAC_BITS = 4,
    parameter int ROOT_W    = 32 + ((FRAC_BITS > 4) ? FRAC_BITS - 4 : 0)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [63:0]       in_val,
    output logic              out_vld,
    output logic [ROOT_W-1:0] out_root
);

    localparam int EXTRA = ROOT_W - 32;
    localparam int VW    = 2 * ROOT_W;
    localparam int RW    = ROOT_W + 2;
    localparam int SHR   = (FRAC_BITS < 4) ? 8 - 2 * FRAC_BITS : 0;

    logic [VW-1:0] v_in;

    logic              vld_reg  [1:ROOT_W];
    logic [VW-1:0]     v_reg    [1:ROOT_W];
    logic [RW-1:0]     rem_reg  [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg [1:ROOT_W];

    // align the radicand: append zero pairs or drop low bits
    assign v_in = (VW'(in_val) << (2 * EXTRA)) >> SHR;

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++)
        begin : g_bit
            logic              v_cur;
            logic [VW-1:0]     val_cur;
            logic [RW-1:0]     rem_cur;
            logic [ROOT_W-1:0] root_cur;
            logic [RW-1:0]     rem_sh;
            logic [RW-1:0]     trial;
            logic [RW-1:0]     rem_next;
            logic [ROOT_W-1:0] root_next;

            if (i == 0)
            begin : g_src_in
                assign v_cur    = in_vld;
                assign val_cur  = v_in;
                assign rem_cur  = '0;
                assign root_cur = '0;
            end
            else
            begin : g_src_reg
                assign v_cur    = vld_reg[i];
                assign val_cur  = v_reg[i];
                assign rem_cur  = rem_reg[i];
                assign root_cur = root_reg[i];
            end

            // bring down the next pair and try the next root bit
            always_comb
            begin
                rem_sh = {rem_cur[RW-3:0], val_cur[VW-1:VW-2]};
                trial  = {root_cur, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_cur[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_cur[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i+1] <= 1'b0;
                else if (en)
                    vld_reg[i+1] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[i+1]    <= val_cur << 2;
                    rem_reg[i+1]  <= rem_next;
                    root_reg[i+1] <= root_next;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[ROOT_W];
    assign out_root = root_reg[ROOT_W];

endmodule

// ===== src/radar_beam_altitude_unit.sv =====
// Pipeline, ROOT_W = 32 + max(ALT_FRAC_BITS - 4, 0): angle stage, one stage per
// CORDIC iteration, three product and sum stages, one stage per root bit, output
// register.
// Throughput: one transfer per cycle; a stalled output holds the whole pipeline.
// Reset: clears all valid bits; site altitude resets to 0, radius to 8494667 m.
// Top level: config registers, product/sum stages, final offset and saturation.
`timescale 1ns / 1ps

module radar_beam_altitude_unit
#(
    parameter int CORDIC_STEPS  = 24,
    parameter int ALT_FRAC_BITS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [19:0] slant_range, [37:20] elevation, [39:38] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [24:0] beam_altitude, [31:25] zero
    output logic [0:0]  m_axis_tuser    // [0] saturated
);

    localparam int ROOT_W = 32 + ((ALT_FRAC_BITS > 4) ? ALT_FRAC_BITS - 4 : 0);
    localparam int AW     = ROOT_W + 2;
    localparam logic signed [AW-1:0] MAX_A = AW'(rba_pkg::OUT_MAX);
    localparam logic signed [AW-1:0] MIN_A = AW'(rba_pkg::OUT_MIN);

    logic [14:0] site_reg;
    logic [23:0] rad_reg;

    logic en;

    logic               ang_vld;
    logic [19:0]        ang_range;
    logic signed [32:0] ang_z;

    logic               cor_vld;
    logic [19:0]        cor_range;
    logic signed [33:0] cor_y;

    logic signed [25:0] h;
    logic signed [33:0] y_clamp;

    logic               p1_vld_reg;
    logic signed [31:0] p1_s_reg;
    logic signed [46:0] p1_rh_reg;
    logic [39:0]        p1_rr_reg;
    logic signed [51:0] p1_hh_reg;

    logic [45:0]        m_mag;
    logic [30:0]        s_mag;

    logic               p2_vld_reg;
    logic [61:0]        p2_hi_reg;
    logic [60:0]        p2_lo_reg;
    logic               p2_neg_reg;
    logic [39:0]        p2_rr_reg;
    logic signed [51:0] p2_hh_reg;

    logic [63:0]        q;
    logic signed [63:0] a_sum;

    logic               p3_vld_reg;
    logic [63:0]        p3_v_reg;

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;

    logic signed [AW-1:0] alt;
    logic [24:0]          alt_sat;
    logic                 sat_flag;

    logic        out_vld_reg;
    logic [24:0] alt_reg;
    logic        sat_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_reg <= '0;
            rad_reg  <= rba_pkg::EFF_RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rba_pkg::CFG_SITE_ALT:   site_reg <= cfg_data[14:0];
                rba_pkg::CFG_EFF_RADIUS: rad_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // whole pipeline advances unless a finished result is waiting
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    rba_angle u_angle
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (s_axis_tvalid),
        .in_range  (s_axis_tdata[19:0]),
        .in_elev   ($signed(s_axis_tdata[37:20])),
        .out_vld   (ang_vld),
        .out_range (ang_range),
        .out_z     (ang_z)
    );

    rba_cordic #(.STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (ang_vld),
        .in_range  (ang_range),
        .in_z      (ang_z),
        .out_vld   (cor_vld),
        .out_range (cor_range),
        .out_y     (cor_y)
    );

    // stage P1: clamp sine, form h, the three products
    always_comb
    begin
        h = $signed({{11{site_reg[14]}}, site_reg}) + $signed({2'b00, rad_reg});
        if (cor_y > rba_pkg::ONE_Q30)
            y_clamp = rba_pkg::ONE_Q30;
        else if (cor_y < -rba_pkg::ONE_Q30)
            y_clamp = -rba_pkg::ONE_Q30;
        else
            y_clamp = cor_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= cor_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_s_reg  <= y_clamp[31:0];
            p1_rh_reg <= $signed({1'b0, cor_range}) * h;
            p1_rr_reg <= cor_range * cor_range;
            p1_hh_reg <= h * h;
        end
    end

    // stage P2: split |r*h| * |sin| into two partial products
    always_comb
    begin
        m_mag = p1_rh_reg[46] ? 46'(-p1_rh_reg) : 46'(p1_rh_reg);
        s_mag = p1_s_reg[31] ? 31'(-p1_s_reg) : 31'(p1_s_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_hi_reg  <= 62'(m_mag) * 62'(s_mag[30:15]);
            p2_lo_reg  <= 61'(m_mag) * 61'(s_mag[14:0]);
            p2_neg_reg <= p1_rh_reg[46] != p1_s_reg[31];
            p2_rr_reg  <= p1_rr_reg;
            p2_hh_reg  <= p1_hh_reg;
        end
    end

    // stage P3: cross term, sum in 1/256 m^2, clamp at zero
    always_comb
    begin
        q = 64'(p2_hi_reg >> 6)
            + ((({58'd0, p2_hi_reg[5:0]} << 15) + 64'(p2_lo_reg)) >> 21);
        a_sum = $signed({16'd0, p2_rr_reg, 8'd0}) + $signed({4'd0, p2_hh_reg, 8'd0});
        if (p2_neg_reg)
            a_sum = a_sum - $signed(q);
        else
            a_sum = a_sum + $signed(q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p3_v_reg <= a_sum[63] ? 64'd0 : a_sum;
    end

    rba_sqrt #(.FRAC_BITS(ALT_FRAC_BITS)) u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p3_vld_reg),
        .in_val   (p3_v_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root)
    );

    // remove the radius and saturate to the output range
    always_comb
    begin
        alt = $signed(AW'(sq_root)) - $signed(AW'(rad_reg) << ALT_FRAC_BITS);
        if (alt > MAX_A)
        begin
            alt_sat  = rba_pkg::OUT_MAX;
            sat_flag = 1'b1;
        end
        else if (alt < MIN_A)
        begin
            alt_sat  = rba_pkg::OUT_MIN;
            sat_flag = 1'b1;
        end
        else
        begin
            alt_sat  = alt[24:0];
            sat_flag = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alt_reg <= alt_sat;
            sat_reg <= sat_flag;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, alt_reg};
    assign m_axis_tuser  = sat_reg;

    // a waiting result is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !m_axis_tready |=> out_vld_reg)
        else $error("result lost while stalled");

    // a saturated result sits at one of the limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && sat_reg |->
            (alt_reg == rba_pkg::OUT_MAX) || (alt_reg == rba_pkg::OUT_MIN))
        else $error("saturation flag without a limit value");

    // an accepted transfer shows up in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> ang_vld)
        else $error("accepted transfer missing from angle stage");

endmodule
